FILE: rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

   // bitmap geometry
   localparam int FRAME_COUNT = 4096;
   localparam int FRAME_W     = 12;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = FRAME_COUNT / WORD_BITS;
   localparam int ROW_W       = $clog2(WORD_COUNT);

   // request operation codes
   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_NOOP = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // work class decided by the front end
   typedef enum logic [1:0] {
      CLS_NOOP  = 2'd0,
      CLS_ALLOC = 2'd1,
      CLS_FREE  = 2'd2
   } class_type;

   // back end sequencer states
   typedef enum logic [0:0] {
      BACK_IDLE   = 1'b0,
      BACK_MODIFY = 1'b1
   } back_state_type;

   // classified command between front and back
   typedef struct packed {
      class_type          cls;
      logic [FRAME_W-1:0] frame;
      logic               kernel;
      logic               writeable;
   } cmd_type;

   // handshake from front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   // one result beat
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               present;
      logic               writable;
      logic               user_mode;
      status_type         status;
   } rsp_type;

   // lowest clear bit of a word, zero when none is clear
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: rtl/bfa_front.sv
`timescale 1ns / 1ps

module bfa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         operation,
   input  logic [bfa_pkg::FRAME_W-1:0]  current_frame,
   input  logic                         kernel,
   input  logic                         writeable,
   output bfa_pkg::cmd_chan_type        chan,
   input  logic                         pop
);
   import bfa_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   cmd_type    cmd_in;
   logic       do_push;
   logic       do_pop;

   // classify the incoming request
   always_comb begin
      cmd_in.frame     = current_frame;
      cmd_in.kernel    = kernel;
      cmd_in.writeable = writeable;
      if (op_type'(operation) == OP_FREE) begin
         if (current_frame == '0 ||
             {1'b0, current_frame} >= (FRAME_W + 1)'(FRAME_COUNT)) begin
            cmd_in.cls = CLS_NOOP;
         end else begin
            cmd_in.cls = CLS_FREE;
         end
      end else begin
         if (current_frame != '0) begin
            cmd_in.cls = CLS_NOOP;
         end else begin
            cmd_in.cls = CLS_ALLOC;
         end
      end
   end

   // two-entry command queue
   assign full       = (count_ff == 2'd2);
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign chan.valid = (count_ff != 2'd0);
   assign chan.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

FILE: rtl/bfa_back.sv
`timescale 1ns / 1ps

module bfa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bfa_pkg::cmd_chan_type chan,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output bfa_pkg::rsp_type      rsp
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0]  bitmap_mem [WORD_COUNT];
   back_state_type        state_ff;
   back_state_type        state_in;
   logic [WORD_COUNT-1:0] row_valid_ff;
   logic [WORD_COUNT-1:0] word_full_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;
   logic [ROW_W-1:0]      row_ff;
   cmd_type               cmd_ff;
   logic                  rd_en;
   logic [ROW_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [WORD_BITS-1:0]  row_word;
   logic [WORD_BITS-1:0]  new_row;
   logic [BIT_W-1:0]      bit_idx;
   logic [WORD_BITS-1:0]  bit_mask;

   // merged row: a row never written reads as all free
   assign row_word = rd_valid_ff ? rd_data_ff : '0;
   assign bit_idx  = (cmd_ff.cls == CLS_ALLOC) ? first_zero(row_word)
                                               : cmd_ff.frame[BIT_W-1:0];
   assign bit_mask = WORD_BITS'(1) << bit_idx;
   assign new_row  = (cmd_ff.cls == CLS_ALLOC) ? (row_word | bit_mask)
                                               : (row_word & ~bit_mask);

   // sequencer: dispatch and read in idle, modify and write back after
   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = chan.cmd.frame[FRAME_W-1:BIT_W];
      rsp      = '{frame: '0, present: 1'b0, writable: 1'b0, user_mode: 1'b0,
                   status: STATUS_NOOP};
      case (state_ff)
         BACK_IDLE: begin
            if (chan.valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (chan.cmd.cls)
                  CLS_ALLOC: begin
                     if (&word_full_ff) begin
                        rsp_push   = 1'b1;
                        rsp.status = STATUS_FULL;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = first_zero(word_full_ff);
                        state_in = BACK_MODIFY;
                     end
                  end
                  CLS_FREE: begin
                     rd_en    = 1'b1;
                     state_in = BACK_MODIFY;
                  end
                  default: begin
                     rsp_push  = 1'b1;
                     rsp.frame = chan.cmd.frame;
                  end
               endcase
            end
         end
         BACK_MODIFY: begin
            wr_en      = 1'b1;
            rsp_push   = 1'b1;
            rsp.status = STATUS_DONE;
            state_in   = BACK_IDLE;
            if (cmd_ff.cls == CLS_ALLOC) begin
               rsp.frame     = {row_ff, bit_idx};
               rsp.present   = 1'b1;
               rsp.writable  = cmd_ff.writeable;
               rsp.user_mode = !cmd_ff.kernel;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // control state and per-row summary bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         row_valid_ff <= '0;
         word_full_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            row_valid_ff[row_ff] <= 1'b1;
            word_full_ff[row_ff] <= &new_row;
         end
      end
   end

   // bitmap memory and captured command
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= bitmap_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
         row_ff      <= rd_addr;
         cmd_ff      <= chan.cmd;
      end
      if (wr_en) begin
         bitmap_mem[row_ff] <= new_row;
      end
   end

endmodule

FILE: rtl/bfa_rsp_queue.sv
`timescale 1ns / 1ps

module bfa_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bfa_pkg::rsp_type push_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output bfa_pkg::rsp_type pop_data
);
   import bfa_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   // two-entry result queue
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/bitmap_frame_allocator_core.sv
`timescale 1ns / 1ps

// First-fit physical frame allocator over a 4096-bit in-use bitmap, all
// frames free after reset (no clearing pass; the bitmap is usable as soon
// as reset is released). Requests enter a two-entry command queue where
// they are classified; results leave through a two-entry result queue, so
// both sides may stall freely. Allocate and free each pass through the back
// end's idle state, which picks a 64-bit row (for allocate, the lowest row
// whose summary bit says it is not full) and reads it from the bitmap
// memory, and its modify state, which modifies the row and writes it back.
// No-op and out-of-frames requests are answered from the idle state alone.
// The single-port row read-modify-write means the back end takes no new
// request until the last one is written back, and it also waits while the
// result queue is full. Frame 0 is allocatable and is returned first after
// reset; freeing frame 0 is a no-op.
module bitmap_frame_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_operation,
   input  logic [bfa_pkg::FRAME_W-1:0] req_current_frame,
   input  logic                        req_kernel,
   input  logic                        req_writeable,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [bfa_pkg::FRAME_W-1:0] rsp_frame,
   output logic                        rsp_present,
   output logic                        rsp_writable,
   output logic                        rsp_user_mode,
   output logic [1:0]                  rsp_status
);
   import bfa_pkg::*;

   cmd_chan_type cmd_chan;
   logic         cmd_pop;
   logic         queue_full;
   logic         back_push;
   rsp_type      back_rsp;
   rsp_type      out_rsp;

   // front end: accept and classify
   bfa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .operation     (req_operation),
      .current_frame (req_current_frame),
      .kernel        (req_kernel),
      .writeable     (req_writeable),
      .chan          (cmd_chan),
      .pop           (cmd_pop)
   );

   // back end: bitmap search and update
   bfa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .chan     (cmd_chan),
      .cmd_pop  (cmd_pop),
      .rsp_full (queue_full),
      .rsp_push (back_push),
      .rsp      (back_rsp)
   );

   // result queue
   bfa_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (queue_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (out_rsp)
   );

   assign rsp_frame     = out_rsp.frame;
   assign rsp_present   = out_rsp.present;
   assign rsp_writable  = out_rsp.writable;
   assign rsp_user_mode = out_rsp.user_mode;
   assign rsp_status    = out_rsp.status;

endmodule
